/* rtl/ubh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants of the uniform-bin histogram.
package ubh_pkg;

  localparam int DEF_MAX_BINS    = 256;
  localparam int DEF_COUNT_WIDTH = 32;

  localparam int VAL_W       = 32;                  // samples and range registers
  localparam int SPAN_W      = 32;                  // a positive span fits unsigned 32
  localparam int BIN_IDX_W   = 9;                   // bins_in_use and bin index width
  localparam int READ_W      = 8;                   // read_bin and result bin width
  localparam int OUT_CNT_W   = 32;                  // reported count width
  localparam int DVD_W       = SPAN_W + BIN_IDX_W;  // dividend width
  localparam int STEP_W      = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [VAL_W-1:0]     RANGE_LOW_RST  = 32'd0;
  localparam logic [VAL_W-1:0]     RANGE_HIGH_RST = 32'd65536;
  localparam logic [BIN_IDX_W-1:0] BINS_RST       = 9'd256;
  localparam logic [VAL_W-1:0]     EDGE_MAX       = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] sample;
    logic [READ_W-1:0]       read_bin;
  } item_t;

  typedef struct packed {
    logic                    counted;
    logic [READ_W-1:0]       bin;
    logic [OUT_CNT_W-1:0]    bin_count;
    logic signed [VAL_W-1:0] bin_lower_edge;
  } result_t;

  typedef enum logic [1:0] {
    CMD_MISS,
    CMD_INC,
    CMD_READ
  } cmd_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [BIN_IDX_W-1:0]    idx;
    logic signed [VAL_W-1:0] lower_edge;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic              long_div;
    logic [DVD_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_MODIFY
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/ubh_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, short or long quotient.
module ubh_div
  import ubh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] divisor;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  quo;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   trial_sub;
  logic              ge;

  always_comb begin
    trial     = {rem, dvd[DVD_W-1]};
    ge        = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.long_div ? STEP_W'(DVD_W) : STEP_W'(BIN_IDX_W);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // short form: quotient is known to fit BIN_IDX_W bits, so the upper
  // dividend bits already form a remainder below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      quo     <= '0;
      if (req.long_div) begin
        rem <= '0;
        dvd <= req.dividend;
      end else begin
        rem <= req.dividend[DVD_W-1:BIN_IDX_W];
        dvd <= req.dividend << SPAN_W;
      end
    end else if (busy) begin
      rem <= ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
      dvd <= dvd << 1;
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

/* rtl/ubh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Front end: config registers, request accept, bin and edge computation.
module ubh_front
  import ubh_pkg::*;
#(
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 clearing,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  output logic                 push,
  output cmd_t                 push_cmd,
  input  logic                 q_full
);

  localparam int BINS_CAP = (MAX_BINS > (2 ** BIN_IDX_W) - 1) ? (2 ** BIN_IDX_W) - 1 : MAX_BINS;

  front_state_t         state;
  front_state_t         state_next;
  logic [VAL_W-1:0]     range_low;
  logic [VAL_W-1:0]     range_high;
  logic [BIN_IDX_W-1:0] bins_in_use;

  logic                 op;
  logic [READ_W-1:0]    read_bin;
  logic [VAL_W:0]       diff;
  logic [VAL_W:0]       span;
  logic [DVD_W-1:0]     prod;
  cmd_t                 cmd;
  cmd_t                 cmd_next;
  logic                 cmd_load;
  logic                 acc;

  logic [BIN_IDX_W-1:0] eff_bins;
  logic                 range_ok;
  logic                 in_range;
  logic                 go_div;
  logic [SPAN_W-1:0]    mul_a;
  logic [BIN_IDX_W-1:0] mul_b;
  logic [DVD_W-1:0]     mul_p;
  logic [DVD_W:0]       edge_sum;
  logic                 edge_sat;
  logic [VAL_W-1:0]     edge_val;

  assign acc = item_valid && !item_stall;

  always_comb begin
    eff_bins = (bins_in_use > BIN_IDX_W'(BINS_CAP)) ? BIN_IDX_W'(BINS_CAP) : bins_in_use;
    range_ok = !span[VAL_W] && (span != '0) && (eff_bins != '0);
    // diff < span implies the quotient stays below bins
    in_range = range_ok && !diff[VAL_W] && (diff[SPAN_W-1:0] < span[SPAN_W-1:0]);
    go_div   = op ? range_ok : in_range;
    mul_a    = op ? span[SPAN_W-1:0] : diff[SPAN_W-1:0];
    mul_b    = op ? BIN_IDX_W'(read_bin) : eff_bins;
    mul_p    = mul_a * mul_b;
    edge_sum = {{(DVD_W + 1 - VAL_W){range_low[VAL_W-1]}}, range_low}
             + {1'b0, div_rsp.quotient};
    edge_sat = !edge_sum[DVD_W] && (edge_sum[DVD_W-1:VAL_W-1] != '0);
    edge_val = edge_sat ? EDGE_MAX : edge_sum[VAL_W-1:0];
  end

  always_comb begin
    cmd_next      = '0;
    cmd_next.kind = CMD_MISS;
    if (state == F_MUL) begin
      if (op) begin
        cmd_next.kind       = CMD_READ;
        cmd_next.idx        = BIN_IDX_W'(read_bin);
        cmd_next.lower_edge = range_low;
      end
    end else if (op) begin
      cmd_next.kind       = CMD_READ;
      cmd_next.idx        = BIN_IDX_W'(read_bin);
      cmd_next.lower_edge = edge_val;
    end else begin
      cmd_next.kind = CMD_INC;
      cmd_next.idx  = div_rsp.quotient[BIN_IDX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (acc) state_next = F_MUL;
      F_MUL:   state_next = go_div ? F_START : F_PUSH;
      F_START: state_next = F_DIV;
      F_DIV:   if (div_rsp.done) state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    item_stall       = (state != F_IDLE) || clearing;
    cmd_load         = ((state == F_MUL) && !go_div) || ((state == F_DIV) && div_rsp.done);
    push             = (state == F_PUSH) && !q_full;
    div_req.start    = (state == F_START);
    div_req.long_div = op;
    div_req.dividend = prod;
    div_req.divisor  = op ? SPAN_W'(eff_bins) : span[SPAN_W-1:0];
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      range_low   <= RANGE_LOW_RST;
      range_high  <= RANGE_HIGH_RST;
      bins_in_use <= BINS_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_LOW:   range_low   <= cfg_data;
          REG_RANGE_HIGH:  range_high  <= cfg_data;
          REG_BINS_IN_USE: bins_in_use <= cfg_data[BIN_IDX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op       <= item.operation;
      read_bin <= item.read_bin;
      diff     <= {item.sample[VAL_W-1], item.sample} - {range_low[VAL_W-1], range_low};
      span     <= {range_high[VAL_W-1], range_high} - {range_low[VAL_W-1], range_low};
    end
    if (state == F_MUL) begin
      prod <= mul_p;
    end
    if (cmd_load) begin
      cmd <= cmd_next;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == F_DIV))
    else $error("divider finished outside the wait state");

  a_inc_below_bins: assert property (@(posedge clk) disable iff (rst)
    (push && (push_cmd.kind == CMD_INC)) |-> (push_cmd.idx < eff_bins) && !op)
    else $error("counted bin not below the bin count");
`endif

endmodule
`default_nettype wire

/* rtl/ubh_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// Short FIFO of classified requests between front and back.
module ubh_queue
  import ubh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(QUEUE_DEPTH)) && !(push && full) && !(pop && empty))
    else $error("request queue overrun or underrun");
`endif

endmodule
`default_nettype wire

/* rtl/ubh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Back end: bin counter memory, read-modify-write, result register.
module ubh_back
  import ubh_pkg::*;
#(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    head,
  input  logic    empty,
  output logic    pop,
  output logic    clearing,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int WIDE_W = 64;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

  logic [COUNT_WIDTH-1:0] counts [MAX_BINS];
  logic [COUNT_WIDTH-1:0] rdata;

  back_state_t            state;
  back_state_t            state_next;
  logic [ADDR_W-1:0]      clr_addr;
  cmd_t                   cur;

  logic                   out_free;
  logic                   head_hit;
  logic                   cur_hit;
  logic                   mem_re;
  logic                   mem_we;
  logic                   load_out;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] sat_inc;
  logic [WIDE_W-1:0]      count_wide;
  logic [OUT_CNT_W-1:0]   count_out;
  result_t                res_next;

  always_comb begin
    out_free   = !result_valid || !result_stall;
    head_hit   = (head.kind == CMD_INC)
              || ((head.kind == CMD_READ) && (32'(head.idx) < 32'(MAX_BINS)));
    cur_hit    = (cur.kind == CMD_INC)
              || ((cur.kind == CMD_READ) && (32'(cur.idx) < 32'(MAX_BINS)));
    sat_inc    = (rdata == '1) ? rdata : rdata + COUNT_WIDTH'(1);
    count_wide = WIDE_W'(rdata);
    count_out  = (count_wide[WIDE_W-1:OUT_CNT_W] != '0) ? '1 : count_wide[OUT_CNT_W-1:0];
  end

  always_comb begin
    res_next = '0;
    case (cur.kind)
      CMD_INC: begin
        res_next.counted = 1'b1;
        res_next.bin     = cur.idx[READ_W-1:0];
      end
      CMD_READ: begin
        res_next.bin            = cur.idx[READ_W-1:0];
        res_next.bin_count      = cur_hit ? count_out : '0;
        res_next.bin_lower_edge = cur.lower_edge;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR:  if (clr_addr == LAST_ADDR) state_next = B_IDLE;
      B_IDLE:   if (!empty) state_next = B_MODIFY;
      B_MODIFY: if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    pop       = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    mem_raddr = ADDR_W'(head.idx);
    mem_waddr = ADDR_W'(cur.idx);
    mem_wdata = '0;
    case (state)
      B_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      B_IDLE: begin
        pop    = !empty;
        mem_re = !empty && head_hit;
      end
      B_MODIFY: begin
        load_out  = out_free;
        mem_we    = out_free && cur_hit;
        mem_wdata = (cur.kind == CMD_INC) ? sat_inc : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load_out) begin
      result <= res_next;
    end
  end

  // write lands before the next request's read, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      counts[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= counts[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_inc_reports_counted: assert property (@(posedge clk) disable iff (rst)
    (load_out && (cur.kind == CMD_INC)) |=> (result_valid && result.counted))
    else $error("counted sample not reported as counted");

  a_clear_covers_all: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == B_CLEAR && state != B_CLEAR) |-> ($past(clr_addr) == LAST_ADDR))
    else $error("clearing pass ended early");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> (!pop && !result_valid))
    else $error("request served during clearing pass");
`endif

endmodule
`default_nettype wire

/* rtl/uniform_bin_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Uniform-bin histogram top level.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   item     | item_valid / item_stall   | item_t: operation, sample, read_bin
//   result   | result_valid / result_stall | result_t: counted, bin, count, edge
//   config   | cfg_we                    | cfg_index, cfg_data (no read-back)
//
// A counted sample holds item_stall while the divider forms a short quotient,
// a read on a valid range while it forms a long one (divider: one quotient bit
// per cycle); others skip it. A full request queue holds item_stall longer,
// until the back end pops. After reset the counter memory is cleared, one bin
// per cycle, with item_stall high; config writes are taken meanwhile. The queue
// and result register let the front run while result_stall is high.
module uniform_bin_histogram
  import ubh_pkg::*;
#(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     push;
  cmd_t     push_cmd;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  cmd_t     head;
  logic     clearing;

  ubh_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clearing   (clearing),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  ubh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ubh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  ubh_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

/* bench/ubh_tb_pkg.sv */
`timescale 1ns / 1ps
// Request opcodes and value limits shared by the histogram bench files.
package ubh_tb_pkg;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam longint S32_MAX = 64'sd2147483647;

endpackage

/* bench/ubh_checker.sv */
`timescale 1ns / 1ps
// Histogram scoreboard: mirrors config and bin counts, predicts and checks results.
module ubh_checker
  import ubh_pkg::*;
  import ubh_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  logic signed [VAL_W-1:0] lo_q;
  logic signed [VAL_W-1:0] hi_q;
  logic [BIN_IDX_W-1:0]    bins_q;
  logic [OUT_CNT_W-1:0]    bin_tally [DEF_MAX_BINS];
  result_t                 expected_q [$];

  // classify or read out one request, updating the tally store
  function automatic result_t bin_outcome(input item_t it);
    result_t r;
    longint  span;
    longint  diff;
    longint  b;
    longint  lower;
    int      nb;
    int      i;
    r = '0;
    span = longint'(hi_q) - longint'(lo_q);
    nb = (bins_q > DEF_MAX_BINS) ? DEF_MAX_BINS : int'(bins_q);
    if (it.operation == OP_SAMPLE) begin
      diff = longint'($signed(it.sample)) - longint'(lo_q);
      if (span > 0 && nb > 0 && diff >= 0) begin
        b = (diff * nb) / span;
        if (b < nb) begin
          if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
          r.counted = 1'b1;
          r.bin     = b[READ_W-1:0];
        end
      end
    end else begin
      i = int'(it.read_bin);
      r.bin       = it.read_bin;
      r.bin_count = bin_tally[i];
      bin_tally[i] = '0;
      lower = longint'(lo_q);
      if (span > 0 && nb > 0) begin
        lower = lower + (longint'(i) * span) / nb;
        if (lower > S32_MAX) lower = S32_MAX;
      end
      r.bin_lower_edge = lower[VAL_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      lo_q   = RANGE_LOW_RST;
      hi_q   = RANGE_HIGH_RST;
      bins_q = BINS_RST;
      foreach (bin_tally[k]) bin_tally[k] = '0;
      expected_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: counted=%0b bin=%0d count=%0d edge=%0d",
                     result.counted, result.bin, result.bin_count,
                     $signed(result.bin_lower_edge));
        end else begin
          want = expected_q.pop_front();
          if (result.counted !== want.counted || result.bin !== want.bin ||
              result.bin_count !== want.bin_count ||
              result.bin_lower_edge !== want.bin_lower_edge) begin
            errors++;
            if (errors <= 10)
              $display({"result mismatch: want counted=%0b bin=%0d count=%0d edge=%0d,",
                        " got counted=%0b bin=%0d count=%0d edge=%0d"},
                       want.counted, want.bin, want.bin_count,
                       $signed(want.bin_lower_edge), result.counted, result.bin,
                       result.bin_count, $signed(result.bin_lower_edge));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_LOW:   lo_q = cfg_data;
          REG_RANGE_HIGH:  hi_q = cfg_data;
          REG_BINS_IN_USE: bins_q = cfg_data[BIN_IDX_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) expected_q.push_back(bin_outcome(item));
    end
    pending = expected_q.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Histogram bench top: clock, reset, request and config stimulus, verdict.
module tb;
  import ubh_pkg::*;
  import ubh_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SEG_REQUESTS  = 71;
  localparam int SEGS_PER_MODE = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  int     errors;
  int     pending;
  int     cycle_cnt;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  longint cur_lo = 0;
  longint cur_hi = 65536;
  int     cur_bins = 256;

  always #1 clk = ~clk;

  uniform_bin_histogram u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ubh_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input longint s);
    send_item(item_t'{operation: OP_SAMPLE, sample: s[VAL_W-1:0],
                      read_bin: READ_W'($urandom)});
  endtask

  task automatic send_read(input int b);
    send_item(item_t'{operation: OP_READ, sample: VAL_W'($urandom),
                      read_bin: b[READ_W-1:0]});
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // all three registers, one write per cycle; junk above the bins field at times
  task automatic set_config(input longint lo, input longint hi, input logic [8:0] nb);
    logic [VAL_W-1:0] junk;
    junk = $urandom_range(1) ? ($urandom & ~32'h1FF) : '0;
    cfg_we    <= 1'b1;
    cfg_index <= REG_RANGE_LOW;
    cfg_data  <= lo[VAL_W-1:0];
    @(negedge clk);
    cfg_index <= REG_RANGE_HIGH;
    cfg_data  <= hi[VAL_W-1:0];
    @(negedge clk);
    cfg_index <= REG_BINS_IN_USE;
    cfg_data  <= junk | {23'd0, nb};
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_lo   = lo;
    cur_hi   = hi;
    cur_bins = int'(nb);
  endtask

  task automatic random_config();
    longint lo;
    longint hi;
    longint span;
    longint a;
    longint b;
    logic [8:0] nb;
    int kind;
    kind = $urandom_range(9);
    span = longint'($urandom >> $urandom_range(31)) + 1;
    if (span > 64'sd4294967295) span = 64'sd4294967295;
    lo = S32_MIN + longint'({$urandom, $urandom} >> 1) % (64'sd4294967296 - span);
    hi = lo + span;
    nb = 9'($urandom_range(256, 1));
    case (kind)
      6: begin
        lo = S32_MIN;
        hi = S32_MAX;
      end
      7: begin
        // inverted or empty range
        a  = longint'($signed($urandom));
        b  = longint'($signed($urandom));
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      8: begin
        lo = longint'($urandom_range(2000)) - 1000;
        hi = lo + $urandom_range(16, 1);
        nb = 9'd256;
      end
      9: nb = $urandom_range(1) ? 9'd0 : 9'($urandom_range(511, 257));
      default: ;
    endcase
    set_config(lo, hi, nb);
  endtask

  function automatic longint pick_sample();
    longint span;
    longint w;
    longint s;
    int     sel;
    span = cur_hi - cur_lo;
    sel  = $urandom_range(99);
    if (span <= 0 || sel < 15) return longint'($signed($urandom));
    if (sel < 25) begin
      case ($urandom_range(3))
        0:       s = cur_lo;
        1:       s = cur_hi - 1;
        2:       s = cur_hi;
        default: s = cur_lo - 1;
      endcase
    end else begin
      w = span + span / 4 + 1;
      s = cur_lo - span / 8 + longint'({$urandom, $urandom} >> 1) % w;
    end
    if (s > S32_MAX) s = S32_MAX;
    if (s < S32_MIN) s = S32_MIN;
    return s;
  endfunction

  task automatic random_request();
    int nb;
    nb = (cur_bins > DEF_MAX_BINS) ? DEF_MAX_BINS : cur_bins;
    if ($urandom_range(99) < 70)
      send_sample(pick_sample());
    else if (nb > 0 && $urandom_range(99) < 80)
      send_read($urandom_range(nb - 1));
    else
      send_read($urandom_range(255));
  endtask

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("uniform_bin_histogram test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset range 0..65536 in 256 bins
    send_sample(0);
    send_sample(65535);
    send_sample(65536);
    send_sample(-1);
    send_sample(S32_MAX);
    send_sample(S32_MIN);
    send_sample(256);
    send_sample(300);
    send_read(0);
    send_read(1);
    send_read(255);
    send_read(128);

    drain();
    set_config(100, 100, 9'd256);      // empty range
    send_sample(100);
    send_read(0);

    drain();
    set_config(-1000, 1000, 9'd0);     // no bins
    send_sample(0);
    send_read(3);

    drain();
    set_config(-1000, 1000, 9'd511);   // clipped to the bin store size
    send_sample(999);
    send_read(255);

    drain();
    set_config(S32_MIN, S32_MAX, 9'd1);
    send_sample(S32_MAX);
    send_sample(S32_MIN);
    send_read(0);
    send_read(255);                    // lower edge saturates

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 83 : 0;
      stall_pct     = (mode == 0) ? 83 : (mode == 1) ? 38 : 0;
      for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
        drain();
        random_config();
        repeat (SEG_REQUESTS) random_request();
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("uniform_bin_histogram test passed");
    else
      $display("uniform_bin_histogram test failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ubh_pkg.sv
rtl/ubh_div.sv
rtl/ubh_front.sv
rtl/ubh_queue.sv
rtl/ubh_back.sv
rtl/uniform_bin_histogram.sv
bench/ubh_tb_pkg.sv
bench/ubh_checker.sv
bench/tb.sv
